FILE: rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersection unit
// Holds the payload structs, the plane record and the divider geometry.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES      = 3;
    localparam int NUM_CFG_REGS  = 6;
    localparam int CFG_IDX_W     = 3;

    // quotient bits resolved per divider stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = 32 / DIV_STEP;
    // prep stage, iteration stages, sign/saturate stage
    localparam int DIV_LAT    = DIV_STAGES + 2;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] BOX_MIN_RST = 32'sd0;
    localparam logic signed [31:0] BOX_MAX_RST = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        limit_t;
    } t_ray_in;

    typedef struct packed {
        logic               is_hit;
        logic [30:0]        hit_t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [1:0]         face_axis;
        logic               normal_positive;
    } t_ray_out;

    typedef struct packed {
        logic signed [31:0] t;
        logic [1:0]         axis;
        logic               pos;
    } t_plane;

    typedef struct packed {
        logic [NUM_AXES-1:0][31:0] org;
        logic [NUM_AXES-1:0][31:0] dir;
        logic [30:0]               limit;
        logic                      outside;
        logic [NUM_AXES-1:0]       zero;
    } t_ctx;

endpackage

FILE: rtl/ray_box_slab_intersection_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_unit: ray versus axis-aligned box, slab method
// Fixed-point Q(32-FRAC_BITS).FRAC_BITS hit test with hit point and face.
// ----------------------------------------------------------------------------
// Usage:
//   Load the box corners through the write port (index 0..2 min x/y/z,
//   3..5 max x/y/z) while no item is in flight. Present a ray on i_ray with
//   i_start high; it is taken at that edge since o_busy stays low, so one
//   item can enter every cycle.
//   Each item yields one result on o_result, marked by o_done for one cycle.
//   The pipeline runs through the six pipelined dividers (two quotient bits per
//   stage), followed by plane ordering, an axis-by-axis entry/exit merge,
//   the hit decision, one 32x32 multiplier stage and the point saturation.
//   Results come out in order and cannot be held off by the receiver.
//   Reset empties the pipeline and loads the unit box [0, 1]^3.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_unit #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  rbsi_pkg::t_ray_in          i_ray,
    output logic                       o_done,
    output rbsi_pkg::t_ray_out         o_result,
    input  logic                       i_cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                i_cfg_data
);
    import rbsi_pkg::*;

    logic signed [31:0] r_box_lo [NUM_AXES];
    logic signed [31:0] r_box_hi [NUM_AXES];

    // input stage
    logic    r_v0;
    t_ray_in r_in0;
    t_ctx    ctx0;

    logic signed [32:0] num_lo [NUM_AXES];
    logic signed [32:0] num_hi [NUM_AXES];
    logic signed [31:0] q_lo   [NUM_AXES];
    logic signed [31:0] q_hi   [NUM_AXES];

    // context delay line alongside the dividers
    logic r_dv   [DIV_LAT];
    t_ctx r_dctx [DIV_LAT];

    // ordered planes per axis
    logic   r_v1;
    t_ctx   r_ctx1;
    t_plane r_lo1 [NUM_AXES];
    t_plane r_hi1 [NUM_AXES];

    // merge of x and y
    logic   r_v2;
    t_ctx   r_ctx2;
    t_plane r_en2, r_lv2, r_lo2z, r_hi2z;
    logic   r_ev2;

    // merge with z
    logic   r_v3;
    t_ctx   r_ctx3;
    t_plane r_en3, r_lv3;
    logic   r_ev3;

    // hit decision
    logic   r_v4;
    t_ctx   r_ctx4;
    logic   r_hit4;
    t_plane r_pick4;

    // products
    logic               r_v5;
    t_ctx               r_ctx5;
    logic               r_hit5;
    t_plane             r_pick5;
    logic signed [63:0] r_prod5 [NUM_AXES];

    logic     r_v6;
    t_ray_out r_out6;

    t_plane n_lo1 [NUM_AXES];
    t_plane n_hi1 [NUM_AXES];
    t_plane n_en2, n_lv2, n_en3, n_lv3, n_pick4;
    logic   n_ev2, n_ev3, n_hit4;
    logic signed [32:0] lim4;
    logic signed [31:0] pt6 [NUM_AXES];
    logic signed [63:0] sum6;

    assign o_busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_box_lo[a] <= BOX_MIN_RST;
                r_box_hi[a] <= BOX_MAX_RST;
            end
        end else if (i_cfg_we) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (i_cfg_idx == REG_BOX_MIN_X + CFG_IDX_W'(a)) begin
                    r_box_lo[a] <= $signed(i_cfg_data);
                end
                if (i_cfg_idx == REG_BOX_MAX_X + CFG_IDX_W'(a)) begin
                    r_box_hi[a] <= $signed(i_cfg_data);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v0    <= i_start;
            r_dv[0] <= r_v0;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_v1 <= r_dv[DIV_LAT-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // slab numerators and zero-direction check
    always_comb begin
        ctx0.org     = {r_in0.origin_z, r_in0.origin_y, r_in0.origin_x};
        ctx0.dir     = {r_in0.dir_z, r_in0.dir_y, r_in0.dir_x};
        ctx0.limit   = r_in0.limit_t;
        ctx0.outside = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            ctx0.zero[a] = (ctx0.dir[a] == 32'd0);
            num_lo[a] = 33'(r_box_lo[a]) - 33'($signed(ctx0.org[a]));
            num_hi[a] = 33'(r_box_hi[a]) - 33'($signed(ctx0.org[a]));
            if (ctx0.zero[a] && ($signed(ctx0.org[a]) < r_box_lo[a]
                                 || $signed(ctx0.org[a]) > r_box_hi[a])) begin
                ctx0.outside = 1'b1;
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
            .i_clk (i_clk),
            .i_num (num_lo[a]),
            .i_den ($signed(ctx0.dir[a])),
            .o_quo (q_lo[a])
        );
        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
            .i_clk (i_clk),
            .i_num (num_hi[a]),
            .i_den ($signed(ctx0.dir[a])),
            .o_quo (q_hi[a])
        );
    end

    // order the two planes of each axis
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (q_lo[a] > q_hi[a]) begin
                n_lo1[a] = '{t: q_hi[a], axis: 2'(a), pos: 1'b1};
                n_hi1[a] = '{t: q_lo[a], axis: 2'(a), pos: 1'b0};
            end else begin
                n_lo1[a] = '{t: q_lo[a], axis: 2'(a), pos: 1'b0};
                n_hi1[a] = '{t: q_hi[a], axis: 2'(a), pos: 1'b1};
            end
        end
    end

    // merge x and y; later axis wins ties
    always_comb begin
        logic vx, vy;
        vx = !r_ctx1.zero[0];
        vy = !r_ctx1.zero[1];
        n_en2 = (vy && (!vx || r_lo1[1].t >= r_lo1[0].t)) ? r_lo1[1] : r_lo1[0];
        n_lv2 = (vy && (!vx || r_hi1[1].t <= r_hi1[0].t)) ? r_hi1[1] : r_hi1[0];
        n_ev2 = vx | vy;
    end

    // merge with z
    always_comb begin
        logic vz;
        vz = !r_ctx2.zero[2];
        n_en3 = (vz && (!r_ev2 || r_lo2z.t >= r_en2.t)) ? r_lo2z : r_en2;
        n_lv3 = (vz && (!r_ev2 || r_hi2z.t <= r_lv2.t)) ? r_hi2z : r_lv2;
        n_ev3 = r_ev2 | vz;
    end

    // hit decision: entry plane first, else exit plane
    always_comb begin
        lim4    = {2'b00, r_ctx3.limit};
        n_hit4  = 1'b0;
        n_pick4 = r_en3;
        if (!r_ctx3.outside && r_ev3 && r_en3.t < r_lv3.t) begin
            if (r_en3.t > 0 && 33'(r_en3.t) < lim4) begin
                n_hit4 = 1'b1;
            end else if (r_lv3.t > 0 && 33'(r_lv3.t) < lim4) begin
                n_hit4  = 1'b1;
                n_pick4 = r_lv3;
            end
        end
    end

    // hit point: floor shift, add origin, saturate
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            sum6 = 64'($signed(r_ctx5.org[a])) + (r_prod5[a] >>> FRAC_BITS);
            if (sum6 > 64'(S32_MAX)) begin
                pt6[a] = S32_MAX;
            end else if (sum6 < 64'(S32_MIN)) begin
                pt6[a] = S32_MIN;
            end else begin
                pt6[a] = sum6[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_in0 <= i_ray;
        end
        r_dctx[0] <= ctx0;
        for (int s = 1; s < DIV_LAT; s++) begin
            r_dctx[s] <= r_dctx[s-1];
        end

        r_ctx1 <= r_dctx[DIV_LAT-1];
        r_lo1  <= n_lo1;
        r_hi1  <= n_hi1;

        r_ctx2 <= r_ctx1;
        r_en2  <= n_en2;
        r_lv2  <= n_lv2;
        r_ev2  <= n_ev2;
        r_lo2z <= r_lo1[2];
        r_hi2z <= r_hi1[2];

        r_ctx3 <= r_ctx2;
        r_en3  <= n_en3;
        r_lv3  <= n_lv3;
        r_ev3  <= n_ev3;

        r_ctx4  <= r_ctx3;
        r_hit4  <= n_hit4;
        r_pick4 <= n_pick4;

        r_ctx5  <= r_ctx4;
        r_hit5  <= r_hit4;
        r_pick5 <= r_pick4;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_prod5[a] <= 64'(r_pick4.t) * 64'($signed(r_ctx4.dir[a]));
        end

        if (r_hit5) begin
            r_out6 <= '{is_hit: 1'b1, hit_t: r_pick5.t[30:0],
                        point_x: pt6[0], point_y: pt6[1], point_z: pt6[2],
                        face_axis: r_pick5.axis, normal_positive: r_pick5.pos};
        end else begin
            r_out6 <= '{is_hit: 1'b0, hit_t: r_ctx5.limit,
                        point_x: 32'sd0, point_y: 32'sd0, point_z: 32'sd0,
                        face_axis: 2'd0, normal_positive: 1'b0};
        end
    end

    assign o_done   = r_v6;
    assign o_result = r_out6;

endmodule

FILE: rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined plane-distance divider
// Computes sat32((num * 2^FRAC_BITS) / den), truncated toward zero, and
// accepts a new operand pair every cycle.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic signed [32:0] i_num,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quo
);
    import rbsi_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int HW = NW - 32;

    logic [32:0]    mag_num;
    logic [NW-1:0]  num_sh;
    logic [31:0]    mag_den;
    logic [HW-1:0]  num_hi;

    logic [63:0] r_w   [DIV_STAGES+1];
    logic [31:0] r_den [DIV_STAGES+1];
    logic        r_neg [DIV_STAGES+1];
    logic        r_ovf [DIV_STAGES+1];
    logic signed [31:0] r_quo;

    always_comb begin
        mag_num = i_num[32] ? 33'(-i_num) : 33'(i_num);
        mag_den = i_den[31] ? 32'(-i_den) : 32'(i_den);
        num_sh  = {mag_num, {FRAC_BITS{1'b0}}};
        num_hi  = num_sh[NW-1:32];
    end

    // step: partial remainder in the upper half, quotient shifts into the lower
    function automatic logic [63:0] div_step(input logic [63:0] w, input logic [31:0] den);
        logic [63:0] acc;
        logic [32:0] trial;
        acc = w;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = acc[63:31];
            if (trial >= {1'b0, den}) begin
                trial = trial - {1'b0, den};
                acc   = {trial[31:0], acc[30:0], 1'b1};
            end else begin
                acc   = {trial[31:0], acc[30:0], 1'b0};
            end
        end
        return acc;
    endfunction

    always_ff @(posedge i_clk) begin
        // quotient would not fit in 32 bits: flag and saturate at the end
        r_ovf[0] <= {{(32 > HW ? 32 - HW : 0){1'b0}}, num_hi} >= 32'(mag_den)
                    || (HW > 32);
        r_w[0]   <= {32'(num_hi), num_sh[31:0]};
        r_den[0] <= mag_den;
        r_neg[0] <= i_num[32] ^ i_den[31];
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_w[s+1]   <= div_step(r_w[s], r_den[s]);
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
        end
        if (r_ovf[DIV_STAGES]) begin
            r_quo <= r_neg[DIV_STAGES] ? S32_MIN : S32_MAX;
        end else if (!r_neg[DIV_STAGES]) begin
            r_quo <= r_w[DIV_STAGES][31] ? S32_MAX : $signed(r_w[DIV_STAGES][31:0]);
        end else if (r_w[DIV_STAGES][31:0] > 32'h8000_0000) begin
            r_quo <= S32_MIN;
        end else begin
            r_quo <= $signed(-r_w[DIV_STAGES][31:0]);
        end
    end

    assign o_quo = r_quo;

endmodule
